// ===== rtl/hcbp_pkg.sv =====
// ----------------------------------------------------------------------------
// hcbp_pkg
// Shared types and constants for the Huffman code bit packer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hcbp_pkg;

  localparam int MAX_CODE_LEN_DEF = 16;  // default longest code accepted
  localparam int CODE_FIELD_W     = 16;  // width of the code_bits field
  localparam int BYTE_W           = 8;
  localparam int SYMBOL_W         = 8;
  localparam int LENGTH_W         = 5;   // width of the code_length field
  localparam int TABLE_DEPTH      = 256;
  localparam int PEND_W           = BYTE_W - 1;

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_ENCODE = 2'd1,
    CMD_FLUSH  = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_DATA   = 2'd0,
    KIND_PADDED = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    kind_t             kind;
    logic              last;
  } res_t;

endpackage

// ===== rtl/huffman_code_bit_packer.sv =====
// ----------------------------------------------------------------------------
// huffman_code_bit_packer
// Table-driven Huffman encoder: byte-indexed code table, bit accumulator,
// MSB-first byte output with zero-padded flush and unknown-symbol errors.
// Path: a taken request passes the lookup register, then the result register,
// before its first result shows on m_*.
// Throughput: one request per cycle while m_tready is high; a request that
// completes two bytes holds the single result port and stalls the next request.
// Reset: rst (sync, high) clears the pipeline, the result buffer, the bit
// accumulator and all table valid bits (every byte unknown).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module huffman_code_bit_packer #(
  parameter int MAX_CODE_LEN = hcbp_pkg::MAX_CODE_LEN_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  // request stream
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [31:0]                s_tdata,   // symbol[7:0], code_bits[23:8],
                                                // code_length[28:24], zero fill
  input  logic [1:0]                 s_tuser,   // command[1:0]
  // result stream
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [hcbp_pkg::BYTE_W-1:0] m_tdata,  // out_byte[7:0]
  output logic [1:0]                 m_tuser,   // kind[1:0]
  output logic                       m_tlast    // last_of_run
);

  import hcbp_pkg::*;

  // Effective longest code: also bounded by the code_bits field width.
  localparam int EFF_LEN = (MAX_CODE_LEN < CODE_FIELD_W) ? MAX_CODE_LEN : CODE_FIELD_W;
  localparam int LW      = $clog2(EFF_LEN + 1);       // stored length width
  localparam int ACC_W   = PEND_W + EFF_LEN;          // pending + one code
  localparam int TW      = $clog2(ACC_W + 1);         // bit total width

  // ---- request unpack ------------------------------------------------------
  cmd_t                  in_cmd;
  logic [SYMBOL_W-1:0]   in_symbol;
  logic [CODE_FIELD_W-1:0] in_code;
  logic [LENGTH_W-1:0]   in_len;
  logic                  in_accept;
  logic                  in_len_ok;

  assign in_cmd    = cmd_t'(s_tuser);
  assign in_symbol = s_tdata[SYMBOL_W-1:0];
  assign in_code   = s_tdata[SYMBOL_W +: CODE_FIELD_W];
  assign in_len    = s_tdata[SYMBOL_W+CODE_FIELD_W +: LENGTH_W];
  assign in_accept = s_tvalid && s_tready;
  // zero or overlong length stores the entry as unknown
  assign in_len_ok = (in_len != '0) && (int'(in_len) <= EFF_LEN);

  // ---- code table ----------------------------------------------------------
  // Bits and length live in a memory; a valid flop per entry gives the
  // all-unknown reset without a clearing pass.
  logic [EFF_LEN-1:0] tbl_bits [TABLE_DEPTH];
  logic [LW-1:0]      tbl_len  [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] tbl_ok;

  always_ff @(posedge clk) begin
    if (in_accept && in_cmd == CMD_LOAD) begin
      // bits at or above the length are dropped
      tbl_bits[in_symbol] <= in_code[EFF_LEN-1:0] & ~({EFF_LEN{1'b1}} << in_len);
      tbl_len[in_symbol]  <= LW'(in_len);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tbl_ok <= '0;
    end else if (in_accept && in_cmd == CMD_LOAD) begin
      tbl_ok[in_symbol] <= in_len_ok;
    end
  end

  // ---- stage 1: registered lookup ------------------------------------------
  // The table read happens at the accept edge, so a load taken in the previous
  // cycle is already visible to the encode that follows it.
  logic                s1_valid;
  cmd_t                s1_cmd;
  logic [SYMBOL_W-1:0] s1_symbol;
  logic [EFF_LEN-1:0]  rd_bits;
  logic [LW-1:0]       rd_len;
  logic                rd_ok;
  logic                s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_cmd    <= in_cmd;
      s1_symbol <= in_symbol;
      rd_bits   <= tbl_bits[in_symbol];
      rd_len    <= tbl_len[in_symbol];
      rd_ok     <= tbl_ok[in_symbol];
    end
  end

  // ---- bit accumulator and result build ------------------------------------
  logic [PEND_W-1:0] pend_bits;
  logic [2:0]        pend_cnt;
  logic [PEND_W-1:0] pend_bits_next;
  logic [2:0]        pend_cnt_next;
  res_t              r0;
  res_t              r1;
  logic [1:0]        r_n;

  always_comb begin
    logic [LW-1:0]    len;
    logic [ACC_W-1:0] acc;
    logic [TW-1:0]    total;
    logic [TW-1:0]    sh0;
    logic [TW-1:0]    sh1;
    logic [ACC_W-1:0] byte0;
    logic [ACC_W-1:0] byte1;
    logic [BYTE_W-1:0] padded;

    len    = rd_ok ? rd_len : '0;
    acc    = (ACC_W'(pend_bits) << len) | ACC_W'(rd_bits);
    total  = TW'(pend_cnt) + TW'(len);
    sh0    = total - TW'(BYTE_W);
    sh1    = total - TW'(2 * BYTE_W);
    byte0  = acc >> sh0;
    byte1  = acc >> sh1;
    padded = {1'b0, pend_bits} << (3'(BYTE_W - 1) - pend_cnt + 3'd1);

    pend_bits_next = pend_bits;
    pend_cnt_next  = pend_cnt;
    r0  = '{data: s1_symbol, kind: KIND_ERROR, last: 1'b1};
    r1  = '{data: byte1[BYTE_W-1:0], kind: KIND_DATA, last: 1'b1};
    r_n = 2'd0;

    case (s1_cmd)
      CMD_ENCODE: begin
        if (!rd_ok) begin
          r_n = 2'd1;  // unknown symbol: error, accumulator untouched
        end else begin
          if (int'(total) >= 2 * BYTE_W) begin
            r_n = 2'd2;
          end else if (int'(total) >= BYTE_W) begin
            r_n = 2'd1;
          end
          r0 = '{data: byte0[BYTE_W-1:0], kind: KIND_DATA, last: (r_n == 2'd1)};
          // remainder count equals total mod 8
          pend_cnt_next  = total[2:0];
          pend_bits_next = acc[PEND_W-1:0] & ~({PEND_W{1'b1}} << total[2:0]);
        end
      end
      CMD_FLUSH: begin
        if (pend_cnt != 3'd0) begin
          r_n = 2'd1;
          r0  = '{data: padded, kind: KIND_PADDED, last: 1'b1};
          pend_bits_next = '0;
          pend_cnt_next  = 3'd0;
        end
      end
      default: begin
        r_n = 2'd0;  // loads done at accept; unused command ignored
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_bits <= '0;
      pend_cnt  <= 3'd0;
    end else if (s1_fire) begin
      pend_bits <= pend_bits_next;
      pend_cnt  <= pend_cnt_next;
    end
  end

  // ---- result buffer: two slots, head drives m_* ---------------------------
  res_t       ob0;
  res_t       ob1;
  logic [1:0] ob_cnt;
  logic       out_pop;

  assign m_tvalid = (ob_cnt != 2'd0);
  assign out_pop  = m_tvalid && m_tready;
  // stage 1 retires only when the buffer drains this cycle
  assign s1_fire  = s1_valid && ((ob_cnt == 2'd0) || (ob_cnt == 2'd1 && out_pop));
  assign s_tready = !s1_valid || s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      ob_cnt <= 2'd0;
    end else if (s1_fire) begin
      ob_cnt <= r_n;
    end else if (out_pop) begin
      ob_cnt <= ob_cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      ob0 <= r0;
      ob1 <= r1;
    end else if (out_pop) begin
      ob0 <= ob1;
    end
  end

  assign m_tdata = ob0.data;
  assign m_tuser = ob0.kind;
  assign m_tlast = ob0.last;

endmodule

// ===== rtl/hcbp_checker.sv =====
// ----------------------------------------------------------------------------
// hcbp_checker
// Port-level checks for the Huffman code bit packer, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hcbp_checker (
  input logic       clk,
  input logic       rst,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic [1:0] m_tuser,
  input logic       m_tlast
);

  import hcbp_pkg::*;

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("result changed while stalled");

  // only a full data byte can be followed by more results of the same request
  a_nonlast_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> m_tuser == KIND_DATA)
    else $error("non-last result is not a data byte");

  // error and padded results always close their request
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == KIND_ERROR || m_tuser == KIND_PADDED) |-> m_tlast)
    else $error("error or padded result without last");

  // reset empties the result buffer
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid right after reset");

endmodule

bind huffman_code_bit_packer hcbp_checker u_hcbp_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
